/* rtl/qar_pkg.sv */
// Shared types and constants for the quaternion arithmetic and rotation unit.
// Depends on nothing; used by qar_hamilton, quaternion_arith_rotate, qar_checker and the testbench.
package qar_pkg;

    localparam int NUM_COMP = 4;

    typedef logic [2:0] mode_t;

    localparam mode_t MODE_ADD = 3'd0;
    localparam mode_t MODE_SUB = 3'd1;
    localparam mode_t MODE_MUL = 3'd2;
    localparam mode_t MODE_CONJ = 3'd3;
    localparam mode_t MODE_ROT = 3'd4;

    // Partial product n of component c is x[n] * y[c ^ n]; a set bit n marks a subtracted term.
    localparam logic [NUM_COMP-1:0] HAM_NEG [NUM_COMP] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};

endpackage

/* rtl/quaternion_arith_rotate.sv */
// Top level of the fixed-point quaternion arithmetic and vector rotation unit.
// Depends on qar_pkg and on two instances of qar_hamilton.
//
// The unit takes one transaction in every clock cycle and never raises busy. Each result
// appears on the result ports with done high, in order, after the five register stages of
// the rotation path: two chained quaternion products, each a register stage of multipliers
// followed by a register stage of add, round and saturate, then the output register. Every
// mode passes through the same five stages.
module quaternion_arith_rotate #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS = 13
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [2:0]                   mode,
    input  logic signed [DATA_WIDTH-1:0] a_r,
    input  logic signed [DATA_WIDTH-1:0] a_i,
    input  logic signed [DATA_WIDTH-1:0] a_j,
    input  logic signed [DATA_WIDTH-1:0] a_k,
    input  logic signed [DATA_WIDTH-1:0] b_r,
    input  logic signed [DATA_WIDTH-1:0] b_i,
    input  logic signed [DATA_WIDTH-1:0] b_j,
    input  logic signed [DATA_WIDTH-1:0] b_k,
    output logic                         done,
    output logic signed [DATA_WIDTH-1:0] res_r,
    output logic signed [DATA_WIDTH-1:0] res_i,
    output logic signed [DATA_WIDTH-1:0] res_j,
    output logic signed [DATA_WIDTH-1:0] res_k,
    output logic                         saturated
);

    localparam int DEPTH = 4;
    localparam logic [DATA_WIDTH-1:0] DMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] DMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    typedef struct packed {
        qar_pkg::mode_t                                mode;
        logic [qar_pkg::NUM_COMP-1:0][DATA_WIDTH-1:0] res;
        logic                                          res_sat;
        logic [qar_pkg::NUM_COMP-1:0][DATA_WIDTH-1:0] cj;
        logic                                          cj_sat;
    } side_t;

    logic signed [DATA_WIDTH-1:0] a_vec  [qar_pkg::NUM_COMP];
    logic signed [DATA_WIDTH-1:0] b_vec  [qar_pkg::NUM_COMP];
    logic signed [DATA_WIDTH-1:0] t_vec  [qar_pkg::NUM_COMP];
    logic signed [DATA_WIDTH-1:0] c_vec  [qar_pkg::NUM_COMP];
    logic signed [DATA_WIDTH-1:0] r_vec  [qar_pkg::NUM_COMP];
    logic                         t_sat;
    logic                         r_sat;
    logic                         accept;

    side_t                        side_next;
    side_t                        side_reg [DEPTH];
    side_t                        side_mid;
    logic [DEPTH-1:0]             valid_reg;
    logic                         done_reg;
    logic [DATA_WIDTH-1:0]        out_next [qar_pkg::NUM_COMP];
    logic [DATA_WIDTH-1:0]        out_reg  [qar_pkg::NUM_COMP];
    logic                         sat_next;
    logic                         sat_reg;

    assign busy = 1'b0;
    assign accept = start & ~busy;

    always_comb
    begin
        a_vec[0] = a_r;
        a_vec[1] = a_i;
        a_vec[2] = a_j;
        a_vec[3] = a_k;
        b_vec[0] = (mode == qar_pkg::MODE_ROT) ? '0 : b_r;
        b_vec[1] = b_i;
        b_vec[2] = b_j;
        b_vec[3] = b_k;
    end

    always_comb
    begin
        logic [DATA_WIDTH:0] s;
        logic                neg_sat;
        side_next = '0;
        side_next.mode = mode;
        side_next.cj[0] = a_vec[0];
        for (int n = 1; n < qar_pkg::NUM_COMP; n++)
        begin
            neg_sat = (a_vec[n] == $signed(DMIN));
            side_next.cj[n] = neg_sat ? DMAX : DATA_WIDTH'(-a_vec[n]);
            side_next.cj_sat = side_next.cj_sat | neg_sat;
        end
        case (mode)
            qar_pkg::MODE_ADD, qar_pkg::MODE_SUB:
            begin
                for (int n = 0; n < qar_pkg::NUM_COMP; n++)
                begin
                    if (mode == qar_pkg::MODE_ADD)
                    begin
                        s = {a_vec[n][DATA_WIDTH-1], a_vec[n]} + {b_vec[n][DATA_WIDTH-1], b_vec[n]};
                    end
                    else
                    begin
                        s = {a_vec[n][DATA_WIDTH-1], a_vec[n]} - {b_vec[n][DATA_WIDTH-1], b_vec[n]};
                    end
                    if (s[DATA_WIDTH] != s[DATA_WIDTH-1])
                    begin
                        side_next.res[n] = s[DATA_WIDTH] ? DMIN : DMAX;
                        side_next.res_sat = 1'b1;
                    end
                    else
                    begin
                        side_next.res[n] = s[DATA_WIDTH-1:0];
                    end
                end
            end
            qar_pkg::MODE_CONJ:
            begin
                side_next.res = side_next.cj;
                side_next.res_sat = side_next.cj_sat;
            end
            default:
            begin
                side_next.res = '0;
                side_next.res_sat = 1'b0;
            end
        endcase
    end

    qar_hamilton #(
        .DATA_WIDTH(DATA_WIDTH),
        .FRAC_BITS(FRAC_BITS)
    ) u_ham_first (
        .clk(clk),
        .x(a_vec),
        .y(b_vec),
        .z(t_vec),
        .sat(t_sat)
    );

    always_comb
    begin
        for (int n = 0; n < qar_pkg::NUM_COMP; n++)
        begin
            c_vec[n] = $signed(side_reg[1].cj[n]);
        end
    end

    qar_hamilton #(
        .DATA_WIDTH(DATA_WIDTH),
        .FRAC_BITS(FRAC_BITS)
    ) u_ham_second (
        .clk(clk),
        .x(t_vec),
        .y(c_vec),
        .z(r_vec),
        .sat(r_sat)
    );

    always_comb
    begin
        side_mid = side_reg[1];
        if (side_reg[1].mode == qar_pkg::MODE_MUL)
        begin
            for (int n = 0; n < qar_pkg::NUM_COMP; n++)
            begin
                side_mid.res[n] = t_vec[n];
            end
            side_mid.res_sat = t_sat;
        end
        else if (side_reg[1].mode == qar_pkg::MODE_ROT)
        begin
            side_mid.res_sat = t_sat | side_reg[1].cj_sat;
        end
    end

    always_comb
    begin
        if (side_reg[3].mode == qar_pkg::MODE_ROT)
        begin
            out_next[0] = '0;
            for (int n = 1; n < qar_pkg::NUM_COMP; n++)
            begin
                out_next[n] = r_vec[n];
            end
            sat_next = side_reg[3].res_sat | r_sat;
        end
        else
        begin
            for (int n = 0; n < qar_pkg::NUM_COMP; n++)
            begin
                out_next[n] = side_reg[3].res[n];
            end
            sat_next = side_reg[3].res_sat;
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= side_next;
        side_reg[1] <= side_reg[0];
        side_reg[2] <= side_mid;
        side_reg[3] <= side_reg[2];
        out_reg <= out_next;
        sat_reg <= sat_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= {valid_reg[DEPTH-2:0], accept};
            done_reg <= valid_reg[DEPTH-1];
        end
    end

    assign done = done_reg;
    assign res_r = out_reg[0];
    assign res_i = out_reg[1];
    assign res_j = out_reg[2];
    assign res_k = out_reg[3];
    assign saturated = sat_reg & done_reg;

endmodule

/* rtl/qar_hamilton.sv */
// Two-stage pipelined Hamilton product with round-to-nearest and saturation.
// Depends on qar_pkg for the component count and the partial product sign table.
module qar_hamilton #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS = 13
) (
    input  logic                         clk,
    input  logic signed [DATA_WIDTH-1:0] x [qar_pkg::NUM_COMP],
    input  logic signed [DATA_WIDTH-1:0] y [qar_pkg::NUM_COMP],
    output logic signed [DATA_WIDTH-1:0] z [qar_pkg::NUM_COMP],
    output logic                         sat
);

    localparam int PW = 2 * DATA_WIDTH;
    localparam int SW = PW + 3;
    localparam logic signed [SW-1:0] MAXV = {{(SW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [SW-1:0] MINV = ~MAXV;
    localparam logic signed [SW-1:0] HALF = SW'(1) << (FRAC_BITS - 1);

    logic signed [PW-1:0]         prod_next [qar_pkg::NUM_COMP][qar_pkg::NUM_COMP];
    logic signed [PW-1:0]         prod_reg  [qar_pkg::NUM_COMP][qar_pkg::NUM_COMP];
    logic signed [DATA_WIDTH-1:0] z_next    [qar_pkg::NUM_COMP];
    logic signed [DATA_WIDTH-1:0] z_reg     [qar_pkg::NUM_COMP];
    logic                         sat_next;
    logic                         sat_reg;

    always_comb
    begin
        for (int c = 0; c < qar_pkg::NUM_COMP; c++)
        begin
            for (int n = 0; n < qar_pkg::NUM_COMP; n++)
            begin
                prod_next[c][n] = x[n] * y[2'(c ^ n)];
            end
        end
    end

    always_comb
    begin
        logic signed [SW-1:0] acc;
        logic signed [SW-1:0] term;
        logic signed [SW-1:0] shifted;
        sat_next = 1'b0;
        for (int c = 0; c < qar_pkg::NUM_COMP; c++)
        begin
            acc = HALF;
            for (int n = 0; n < qar_pkg::NUM_COMP; n++)
            begin
                term = SW'(prod_reg[c][n]);
                if (qar_pkg::HAM_NEG[c][n])
                begin
                    acc = acc - term;
                end
                else
                begin
                    acc = acc + term;
                end
            end
            shifted = acc >>> FRAC_BITS;
            if (shifted > MAXV)
            begin
                z_next[c] = MAXV[DATA_WIDTH-1:0];
                sat_next = 1'b1;
            end
            else if (shifted < MINV)
            begin
                z_next[c] = MINV[DATA_WIDTH-1:0];
                sat_next = 1'b1;
            end
            else
            begin
                z_next[c] = shifted[DATA_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        z_reg <= z_next;
        sat_reg <= sat_next;
    end

    assign z = z_reg;
    assign sat = sat_reg;

endmodule

/* tb/qar_checker.sv */
// Watches the command and result channels of quaternion_arith_rotate and predicts each result.
// It counts mismatches and the results still owed. Depends on qar_pkg for the mode codes.
module qar_checker #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS = 13
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic [2:0]                   mode,
    input  logic signed [DATA_WIDTH-1:0] a_r,
    input  logic signed [DATA_WIDTH-1:0] a_i,
    input  logic signed [DATA_WIDTH-1:0] a_j,
    input  logic signed [DATA_WIDTH-1:0] a_k,
    input  logic signed [DATA_WIDTH-1:0] b_r,
    input  logic signed [DATA_WIDTH-1:0] b_i,
    input  logic signed [DATA_WIDTH-1:0] b_j,
    input  logic signed [DATA_WIDTH-1:0] b_k,
    input  logic                         done,
    input  logic signed [DATA_WIDTH-1:0] res_r,
    input  logic signed [DATA_WIDTH-1:0] res_i,
    input  logic signed [DATA_WIDTH-1:0] res_j,
    input  logic signed [DATA_WIDTH-1:0] res_k,
    input  logic                         saturated,
    output int                           mismatches,
    output int                           in_flight
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        longint r;
        longint i;
        longint j;
        longint k;
    } quat_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] r;
        logic [DATA_WIDTH-1:0] i;
        logic [DATA_WIDTH-1:0] j;
        logic [DATA_WIDTH-1:0] k;
        logic                  sat;
    } quat_result_t;

    localparam longint WORD_MAX = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
    localparam longint WORD_MIN = -(longint'(1) <<< (DATA_WIDTH - 1));
    localparam longint HALF_LSB = longint'(1) <<< (FRAC_BITS - 1);

    quat_result_t owed_results[$];

    function automatic longint clamp_word(input longint v, inout bit clamped);
        if (v > WORD_MAX)
        begin
            clamped = 1'b1;
            return WORD_MAX;
        end
        if (v < WORD_MIN)
        begin
            clamped = 1'b1;
            return WORD_MIN;
        end
        return v;
    endfunction

    function automatic longint round_clamp(input longint acc, inout bit clamped);
        return clamp_word((acc + HALF_LSB) >>> FRAC_BITS, clamped);
    endfunction

    function automatic quat_t hamilton_product(input quat_t x, input quat_t y,
                                               inout bit clamped);
        quat_t z;
        z.r = round_clamp(x.r * y.r - x.i * y.i - x.j * y.j - x.k * y.k, clamped);
        z.i = round_clamp(x.r * y.i + x.i * y.r + x.j * y.k - x.k * y.j, clamped);
        z.j = round_clamp(x.r * y.j - x.i * y.k + x.j * y.r + x.k * y.i, clamped);
        z.k = round_clamp(x.r * y.k + x.i * y.j - x.j * y.i + x.k * y.r, clamped);
        return z;
    endfunction

    function automatic quat_result_t predict_result(input logic [2:0] op, input quat_t a,
                                                    input quat_t b);
        quat_t r;
        quat_t t;
        quat_t c;
        bit clamped;
        quat_result_t res;
        clamped = 1'b0;
        r = '0;
        case (op)
            qar_pkg::MODE_ADD:
            begin
                r.r = clamp_word(a.r + b.r, clamped);
                r.i = clamp_word(a.i + b.i, clamped);
                r.j = clamp_word(a.j + b.j, clamped);
                r.k = clamp_word(a.k + b.k, clamped);
            end
            qar_pkg::MODE_SUB:
            begin
                r.r = clamp_word(a.r - b.r, clamped);
                r.i = clamp_word(a.i - b.i, clamped);
                r.j = clamp_word(a.j - b.j, clamped);
                r.k = clamp_word(a.k - b.k, clamped);
            end
            qar_pkg::MODE_MUL:
            begin
                r = hamilton_product(a, b, clamped);
            end
            qar_pkg::MODE_CONJ:
            begin
                r.r = a.r;
                r.i = clamp_word(-a.i, clamped);
                r.j = clamp_word(-a.j, clamped);
                r.k = clamp_word(-a.k, clamped);
            end
            qar_pkg::MODE_ROT:
            begin
                b.r = 0;
                t = hamilton_product(a, b, clamped);
                c.r = a.r;
                c.i = clamp_word(-a.i, clamped);
                c.j = clamp_word(-a.j, clamped);
                c.k = clamp_word(-a.k, clamped);
                r = hamilton_product(t, c, clamped);
                r.r = 0;
            end
            default:
            begin
            end
        endcase
        res.r = r.r[DATA_WIDTH-1:0];
        res.i = r.i[DATA_WIDTH-1:0];
        res.j = r.j[DATA_WIDTH-1:0];
        res.k = r.k[DATA_WIDTH-1:0];
        res.sat = clamped;
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [DATA_WIDTH-1:0] want,
                                        input logic [DATA_WIDTH-1:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
        end
    endfunction

    initial
    begin
        mismatches = 0;
        in_flight = 0;
    end

    always @(posedge clk)
    begin
        quat_result_t want;
        if (rst_n)
        begin
            if (start && !busy)
                owed_results.push_back(predict_result(mode,
                    '{longint'(a_r), longint'(a_i), longint'(a_j), longint'(a_k)},
                    '{longint'(b_r), longint'(b_i), longint'(b_j), longint'(b_k)}));
            if (done)
            begin
                if (owed_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result with no transaction outstanding, got %h %h %h %h %b",
                             $time, res_r, res_i, res_j, res_k, saturated);
                end
                else
                begin
                    want = owed_results.pop_front();
                    check_field("res_r", want.r, res_r);
                    check_field("res_i", want.i, res_i);
                    check_field("res_j", want.j, res_j);
                    check_field("res_k", want.k, res_k);
                    check_field("saturated", DATA_WIDTH'(want.sat), DATA_WIDTH'(saturated));
                end
            end
        end
        in_flight <= owed_results.size();
    end

endmodule

/* tb/quaternion_arith_rotate_tb.sv */
// Stimulus and verdict for quaternion_arith_rotate: directed corner transactions, then random ones.
// Depends on qar_pkg, the block itself and qar_checker, which does all the checking.
module quaternion_arith_rotate_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW = 16;
    localparam int FB = 13;
    localparam qar_pkg::mode_t MODE_SPARE_LO = 3'd5;
    localparam qar_pkg::mode_t MODE_SPARE_MID = 3'd6;
    localparam qar_pkg::mode_t MODE_SPARE_HI = 3'd7;
    localparam logic signed [DW-1:0] WMAX = 16'sh7FFF;
    localparam logic signed [DW-1:0] WMIN = 16'sh8000;
    localparam logic signed [DW-1:0] ONE = 16'sd8192;
    localparam logic signed [DW-1:0] HALF = 16'sd4096;
    localparam logic signed [DW-1:0] COS45 = 16'sd5793;
    localparam int ITEMS_PER_PHASE = 234;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [2:0] mode = qar_pkg::MODE_ADD;
    logic signed [DW-1:0] a_r = '0;
    logic signed [DW-1:0] a_i = '0;
    logic signed [DW-1:0] a_j = '0;
    logic signed [DW-1:0] a_k = '0;
    logic signed [DW-1:0] b_r = '0;
    logic signed [DW-1:0] b_i = '0;
    logic signed [DW-1:0] b_j = '0;
    logic signed [DW-1:0] b_k = '0;
    logic done;
    logic signed [DW-1:0] res_r;
    logic signed [DW-1:0] res_i;
    logic signed [DW-1:0] res_j;
    logic signed [DW-1:0] res_k;
    logic saturated;
    int mismatches;
    int in_flight;
    int idle_pct = 0;

    always #6 clk = ~clk;

    quaternion_arith_rotate #(
        .DATA_WIDTH(DW),
        .FRAC_BITS(FB)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .mode(mode),
        .a_r(a_r),
        .a_i(a_i),
        .a_j(a_j),
        .a_k(a_k),
        .b_r(b_r),
        .b_i(b_i),
        .b_j(b_j),
        .b_k(b_k),
        .done(done),
        .res_r(res_r),
        .res_i(res_i),
        .res_j(res_j),
        .res_k(res_k),
        .saturated(saturated)
    );

    qar_checker #(
        .DATA_WIDTH(DW),
        .FRAC_BITS(FB)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .mode(mode),
        .a_r(a_r),
        .a_i(a_i),
        .a_j(a_j),
        .a_k(a_k),
        .b_r(b_r),
        .b_i(b_i),
        .b_j(b_j),
        .b_k(b_k),
        .done(done),
        .res_r(res_r),
        .res_i(res_i),
        .res_j(res_j),
        .res_k(res_k),
        .saturated(saturated),
        .mismatches(mismatches),
        .in_flight(in_flight)
    );

    task automatic send_command(input qar_pkg::mode_t op,
                                input logic signed [DW-1:0] ar, input logic signed [DW-1:0] ai,
                                input logic signed [DW-1:0] aj, input logic signed [DW-1:0] ak,
                                input logic signed [DW-1:0] br, input logic signed [DW-1:0] bi,
                                input logic signed [DW-1:0] bj, input logic signed [DW-1:0] bk);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        mode <= op;
        a_r <= ar;
        a_i <= ai;
        a_j <= aj;
        a_k <= ak;
        b_r <= br;
        b_i <= bi;
        b_j <= bj;
        b_k <= bk;
        do
            @(posedge clk);
        while (busy);
    endtask

    function automatic logic signed [DW-1:0] pick_word();
        case ($urandom_range(7))
            0: return WMAX;
            1: return WMIN;
            2: return '0;
            3, 4: return DW'(int'($urandom_range(16384)) - 8192);
            default: return DW'($urandom);
        endcase
    endfunction

    function automatic qar_pkg::mode_t pick_mode();
        int v;
        v = $urandom_range(15);
        if (v == 15)
            return qar_pkg::mode_t'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
        return qar_pkg::mode_t'(v % 5);
    endfunction

    initial
    begin
        #5_000_000;
        $display("quaternion_arith_rotate_tb NOT OK");
        $finish;
    end

    initial
    begin
        int guard;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        idle_pct = 28;
        send_command(qar_pkg::MODE_ADD, 0, 0, 0, 0, 0, 0, 0, 0);
        send_command(qar_pkg::MODE_ADD, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX);
        send_command(qar_pkg::MODE_ADD, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN);
        send_command(qar_pkg::MODE_ADD, WMAX, WMIN, WMAX, WMIN, WMIN, WMAX, WMIN, WMAX);
        send_command(qar_pkg::MODE_SUB, WMIN, WMIN, WMIN, WMIN, WMAX, WMAX, WMAX, WMAX);
        send_command(qar_pkg::MODE_SUB, WMAX, WMAX, WMAX, WMAX, WMIN, WMIN, WMIN, WMIN);
        send_command(qar_pkg::MODE_SUB, 0, 100, -100, 7, WMIN, 50, 60, -70);
        send_command(qar_pkg::MODE_MUL, ONE, 0, 0, 0, ONE, 0, 0, 0);
        send_command(qar_pkg::MODE_MUL, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX);
        send_command(qar_pkg::MODE_MUL, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN);
        send_command(qar_pkg::MODE_MUL, 1, 0, 0, 0, HALF, 0, 0, 0);
        send_command(qar_pkg::MODE_MUL, -1, 0, 0, 0, HALF, 0, 0, 0);
        send_command(qar_pkg::MODE_MUL, WMAX, WMIN, WMAX, WMIN, WMIN, WMAX, WMIN, WMAX);
        send_command(qar_pkg::MODE_MUL, 0, ONE, 0, 0, 0, 0, ONE, 0);
        send_command(qar_pkg::MODE_CONJ, 1234, -5678, 910, -1112, WMAX, WMIN, 1, -1);
        send_command(qar_pkg::MODE_CONJ, WMAX, WMIN, WMIN, WMIN, 0, 0, 0, 0);
        send_command(qar_pkg::MODE_CONJ, WMIN, WMAX, 0, WMIN, 0, 0, 0, 0);
        send_command(qar_pkg::MODE_ROT, ONE, 0, 0, 0, 0, 1000, -2000, 3000);
        send_command(qar_pkg::MODE_ROT, COS45, 0, 0, COS45, 0, ONE, 0, 0);
        send_command(qar_pkg::MODE_ROT, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX);
        send_command(qar_pkg::MODE_ROT, ONE, WMIN, 0, 0, 0, 500, 500, 500);
        send_command(qar_pkg::MODE_ROT, COS45, COS45, 0, 0, WMIN, 0, ONE, -ONE);
        send_command(MODE_SPARE_LO, WMAX, 1, 2, 3, 4, 5, 6, WMIN);
        send_command(MODE_SPARE_MID, WMIN, WMIN, WMIN, WMIN, WMAX, WMAX, WMAX, WMAX);
        send_command(MODE_SPARE_HI, -1, -1, -1, -1, -1, -1, -1, -1);

        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 28 : (phase == 1) ? 63 : 0;
            repeat (ITEMS_PER_PHASE)
                send_command(pick_mode(), pick_word(), pick_word(), pick_word(), pick_word(),
                             pick_word(), pick_word(), pick_word(), pick_word());
        end
        @(negedge clk);
        start <= 1'b0;

        guard = 0;
        while (in_flight != 0 && guard < 1000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (10) @(posedge clk);
        if (mismatches == 0 && in_flight == 0)
            $display("quaternion_arith_rotate_tb OK");
        else
            $display("quaternion_arith_rotate_tb NOT OK");
        $finish;
    end

endmodule

/* sim.f */
rtl/qar_pkg.sv
rtl/qar_hamilton.sv
rtl/quaternion_arith_rotate.sv
tb/qar_checker.sv
tb/quaternion_arith_rotate_tb.sv
